### rtl/address_hit_count_table_unit_macros.svh
// Assertion macros used by the file that checks this block.
`ifndef ADDRESS_HIT_COUNT_TABLE_UNIT_MACROS_SVH
`define ADDRESS_HIT_COUNT_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AHT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("aht check failed");

// The consequent must hold in the cycle after the antecedent.
`define AHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("aht check failed");

`endif

### rtl/aht_pkg.sv
package aht_pkg;

    // Default number of table entries.
    localparam int CAPACITY_DEF = 1024;

    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 16;
    localparam int MOD_W   = 16;
    localparam int HITS_W  = 32;
    localparam int UNITS_W = 11;
    localparam int SUM_W   = 42;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_RECORDED = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    // Control sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE,
        S_UPDATE,
        S_EMIT
    } t_state;

    // One table entry as stored in memory.
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  block_length;
        logic [MOD_W-1:0]  module_number;
        logic [HITS_W-1:0] hits;
    } t_entry;

    // One finished result word.
    typedef struct packed {
        t_status            status;
        logic [HITS_W-1:0]  entry_hits;
        logic               entry_is_new;
        logic [UNITS_W-1:0] units_used;
        logic [SUM_W-1:0]   all_hits;
    } t_result;

endpackage

### rtl/aht_rec_if.sv
// Input channel: one coverage record per word.
interface aht_rec_if;
    logic        valid;
    logic        ready;
    logic [63:0] address;
    logic [15:0] block_length;
    logic [15:0] module_number;
    logic [31:0] hits_to_add;

    modport source (output valid, address, block_length, module_number, hits_to_add,
                    input ready);
    modport sink   (input valid, address, block_length, module_number, hits_to_add,
                    output ready);
endinterface

### rtl/aht_res_if.sv
// Output channel: one result per record.
interface aht_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] entry_hits;
    logic        entry_is_new;
    logic [10:0] units_used;
    logic [41:0] all_hits;

    modport source (output valid, status, entry_hits, entry_is_new, units_used, all_hits,
                    input ready);
    modport sink   (input valid, status, entry_hits, entry_is_new, units_used, all_hits,
                    output ready);
endinterface

### rtl/address_hit_count_table_unit.sv
// Address hit-count table.
// Records arrive on i_rec as words carrying an address, block length, module
// number and hit count; one result word per record leaves on o_res.
// A record with a zero address or zero hits is answered as ignored. Otherwise
// the address is hashed into the table memory and probed linearly, one entry
// per cycle, until the matching entry or an empty slot turns up. The entry is
// then rewritten with its saturated count; if no slot is left the record is
// reported as dropped.
// From acceptance, an ignored record goes straight from S_IDLE to S_EMIT,
// while a stored one passes through S_PROBE, one step per entry probed, and
// S_UPDATE before S_EMIT; a drop on a full table probes all CAPACITY entries
// and goes from S_PROBE to S_EMIT. One record is in work at a time and the
// next is taken the cycle after its result word leaves the sequencer.
// After reset the block sweeps the memory to clear every entry's valid mark,
// one entry per cycle; i_rec.ready stays low meanwhile.
// A finished result sits in an output register, so a new record is taken
// while the receiver stalls; the sequencer waits only if a second result is
// ready before the first has gone.
`include "address_hit_count_table_unit_macros.svh"

module address_hit_count_table_unit
    import aht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    aht_rec_if.sink  i_rec,
    aht_res_if.source o_res
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             res_valid;
    logic             res_ready;
    t_result          res;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    t_entry           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    t_entry           wr_data;
    logic             r_out_valid;
    t_result          r_out;
    logic             out_skipped;
    logic             out_blank;
    logic             out_new;
    logic             out_counted;

    aht_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rec       (i_rec),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_rd_en     (rd_en),
        .o_rd_idx    (rd_idx),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_idx    (wr_idx),
        .o_wr_data   (wr_data)
    );

    aht_table #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data)
    );

    // Output register; it takes a new word whenever it is empty or draining.
    assign res_ready = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out.status;
    assign o_res.entry_hits   = r_out.entry_hits;
    assign o_res.entry_is_new = r_out.entry_is_new;
    assign o_res.units_used   = r_out.units_used;
    assign o_res.all_hits     = r_out.all_hits;

    // Conditions on the offered result word that the checks below use.
    assign out_skipped = o_res.valid && (o_res.status == ST_IGNORED || o_res.status == ST_FULL);
    assign out_blank   = (o_res.entry_hits == '0) && !o_res.entry_is_new;
    assign out_new     = o_res.valid && o_res.entry_is_new;
    assign out_counted = (o_res.status == ST_RECORDED) && (o_res.units_used != '0);

    // An ignored or dropped record never reports a count or a new entry.
    `AHT_ASSERT_SAME(a_no_count_unless_recorded, out_skipped, out_blank)
    // A newly created entry is a recorded one and is counted in the totals.
    `AHT_ASSERT_SAME(a_new_entry_counted, out_new, out_counted)
    // Only one record is in work at a time.
    `AHT_ASSERT_NEXT(a_one_record_in_work, i_rec.valid && i_rec.ready, !i_rec.ready)

endmodule

### rtl/aht_table.sv
module aht_table
    import aht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_entry           o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_entry           i_wr_data
);

    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/aht_ctrl.sv
module aht_ctrl
    import aht_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    aht_rec_if.sink          i_rec,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output t_result          o_res,
    output logic             o_rd_en,
    output logic [IDX_W-1:0] o_rd_idx,
    input  t_entry           i_rd_data,
    output logic             o_wr_en,
    output logic [IDX_W-1:0] o_wr_idx,
    output t_entry           o_wr_data
);

    t_state r_state, n_state;

    logic [IDX_W-1:0]  r_clr_idx;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_probes;
    logic [CNT_W-1:0]  r_used;
    logic [SUM_W-1:0]  r_sum;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic [MOD_W-1:0]  r_mod;
    logic [HITS_W-1:0] r_hits;
    t_status           r_status;
    logic [HITS_W-1:0] r_ehits;
    logic              r_isnew;

    logic              accept;
    logic              ignore_rec;
    logic [IDX_W-1:0]  hash_fold;
    logic [IDX_W-1:0]  hash_idx;
    logic [IDX_W-1:0]  idx_next;
    logic              slot_hit;
    logic              slot_empty;
    logic              probes_done;
    logic              table_full;
    logic [HITS_W-1:0] old_hits;
    logic [HITS_W:0]   hit_sum33;
    logic [HITS_W-1:0] new_hits;

    assign accept     = i_rec.valid && i_rec.ready;
    assign ignore_rec = (i_rec.address == '0) || (i_rec.hits_to_add == '0);

    // Fold the address down to an index, then bring it below the capacity.
    always_comb begin
        hash_fold = '0;
        for (int b = 0; b < ADDR_W; b++) begin
            hash_fold[b % IDX_W] = hash_fold[b % IDX_W] ^ i_rec.address[b];
        end
        if (CNT_W'(hash_fold) >= CNT_W'(CAPACITY)) begin
            hash_idx = hash_fold - IDX_W'(CAPACITY);
        end else begin
            hash_idx = hash_fold;
        end
    end

    // Probe decode on the entry read in the previous cycle.
    assign idx_next    = (r_idx == IDX_W'(CAPACITY - 1)) ? '0 : r_idx + 1'b1;
    assign slot_hit    = i_rd_data.valid && (i_rd_data.address == r_addr);
    assign slot_empty  = !i_rd_data.valid;
    assign probes_done = (r_probes == CNT_W'(CAPACITY - 1));
    assign table_full  = (r_used >= CNT_W'(CAPACITY));

    // Saturating add of the record's hits to the entry.
    assign old_hits  = r_isnew ? '0 : i_rd_data.hits;
    assign hit_sum33 = {1'b0, old_hits} + {1'b0, r_hits};
    assign new_hits  = hit_sum33[HITS_W] ? '1 : hit_sum33[HITS_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == IDX_W'(CAPACITY - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = ignore_rec ? S_EMIT : S_PROBE;
                end
            end
            S_PROBE: begin
                if (slot_hit) begin
                    n_state = S_UPDATE;
                end else if (slot_empty) begin
                    n_state = table_full ? S_EMIT : S_UPDATE;
                end else if (probes_done) begin
                    n_state = S_EMIT;
                end
            end
            S_UPDATE: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Memory requests, handshakes and result word.
    always_comb begin
        i_rec.ready = 1'b0;
        o_res_valid = 1'b0;
        o_rd_en     = 1'b0;
        o_rd_idx    = idx_next;
        o_wr_en     = 1'b0;
        o_wr_idx    = r_idx;
        o_wr_data   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_wr_en  = 1'b1;
                o_wr_idx = r_clr_idx;
            end
            S_IDLE: begin
                i_rec.ready = 1'b1;
                o_rd_idx    = hash_idx;
                o_rd_en     = i_rec.valid && !ignore_rec;
            end
            S_PROBE: begin
                o_rd_en = !slot_hit && !slot_empty && !probes_done;
            end
            S_UPDATE: begin
                o_wr_en                 = 1'b1;
                o_wr_data.valid         = 1'b1;
                o_wr_data.address       = r_addr;
                o_wr_data.hits          = new_hits;
                o_wr_data.module_number = r_isnew ? r_mod : i_rd_data.module_number;
                if (r_isnew || (i_rd_data.block_length == '0)) begin
                    o_wr_data.block_length = r_len;
                end else begin
                    o_wr_data.block_length = i_rd_data.block_length;
                end
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
        o_res.status       = r_status;
        o_res.entry_hits   = r_ehits;
        o_res.entry_is_new = r_isnew;
        o_res.units_used   = UNITS_W'(r_used);
        o_res.all_hits     = r_sum;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_used    <= '0;
            r_sum     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (r_state == S_UPDATE) begin
                r_sum <= r_sum + SUM_W'(new_hits - old_hits);
                if (r_isnew) begin
                    r_used <= r_used + 1'b1;
                end
            end
        end
    end

    // Record and result payload.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_addr   <= i_rec.address;
                    r_len    <= i_rec.block_length;
                    r_mod    <= i_rec.module_number;
                    r_hits   <= i_rec.hits_to_add;
                    r_idx    <= hash_idx;
                    r_probes <= '0;
                    r_status <= ST_IGNORED;
                    r_ehits  <= '0;
                    r_isnew  <= 1'b0;
                end
            end
            S_PROBE: begin
                if (slot_hit) begin
                    r_isnew <= 1'b0;
                end else if (slot_empty) begin
                    r_isnew  <= !table_full;
                    r_status <= ST_FULL;
                end else if (probes_done) begin
                    r_status <= ST_FULL;
                end else begin
                    r_idx    <= idx_next;
                    r_probes <= r_probes + 1'b1;
                end
            end
            S_UPDATE: begin
                r_status <= ST_RECORDED;
                r_ehits  <= new_hits;
            end
            default: begin
            end
        endcase
    end

endmodule
